// ----- rtl/core/prl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the port rate limiter.
// No dependencies; used by every module in rtl/core.
package prl_pkg;

  localparam int CNT_W      = 40;  // outstanding bit count, Q8, signed
  localparam int ACC_W      = CNT_W + 1;
  localparam int BYTES_W    = 10;
  localparam int SUM_W      = 11;  // line bytes + preamble + gap
  localparam int BYTE_SHIFT = 11;  // bytes -> Q8 bits: * 8 * 256
  localparam int DRAIN_W    = 24;
  localparam int LEVEL_W    = 20;
  localparam int CHARGE_W   = 8;
  localparam int TICKS_W    = 8;
  localparam int FLOOR_W    = DRAIN_W + TICKS_W;
  localparam int THR_W      = LEVEL_W + BYTE_SHIFT + 1;
  localparam int Q_W        = ACC_W - BYTE_SHIFT;
  localparam int OUT_W      = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // 7 bits in Q8, the round-up term of (bits + 7) / 8
  localparam logic signed [ACC_W-1:0] ROUND_Q8 = ACC_W'(7 * 256);
  localparam logic signed [THR_W-1:0] ROUND_THR = THR_W'(7 * 256);

  localparam logic [CHARGE_W-1:0] PREAMBLE_RST = CHARGE_W'(8);
  localparam logic [CHARGE_W-1:0] GAP_RST      = CHARGE_W'(12);

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_RAW   = 2'd2
  } prl_cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DRAIN    = 3'd0,
    REG_PREAMBLE = 3'd1,
    REG_GAP      = 3'd2,
    REG_XOFF     = 3'd3,
    REG_XON      = 3'd4,
    REG_CREDIT   = 3'd5
  } prl_reg_t;

  typedef struct packed {
    prl_cmd_t           cmd;
    logic               sop;
    logic               eop;
    logic [BYTES_W-1:0] line_bytes;
  } prl_item_t;

  // Register values plus terms derived from them for the update stage
  typedef struct packed {
    logic [DRAIN_W-1:0]  drain_q8;
    logic [CHARGE_W-1:0] preamble;
    logic [CHARGE_W-1:0] gap;
    logic [FLOOR_W:0]    floor_neg;  // -(drain * credit_ticks), signed
    logic [THR_W-1:0]    xoff_thr;   // (xoff_level << 11) - 1792, signed
    logic [THR_W-1:0]    xon_thr;    // (xon_level << 11) - 1792, signed
  } prl_cfg_t;

  // Clamp a widened sum back into the count range
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [ACC_W-1:0] v);
    logic [CNT_W-1:0] res;
    case (v[ACC_W-1:ACC_W-2])
      2'b01:   res = {1'b0, {(CNT_W-1){1'b1}}};
      2'b10:   res = {1'b1, {(CNT_W-1){1'b0}}};
      default: res = v[CNT_W-1:0];
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/prl_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers of the rate limiter and the terms derived from them.
// Depends on prl_pkg.
module prl_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [prl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [prl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output prl_pkg::prl_cfg_t               cfg
);
  import prl_pkg::*;

  logic [DRAIN_W-1:0]  drain_r;
  logic [CHARGE_W-1:0] preamble_r;
  logic [CHARGE_W-1:0] gap_r;
  logic [LEVEL_W-1:0]  xoff_r;
  logic [LEVEL_W-1:0]  xon_r;
  logic [TICKS_W-1:0]  credit_r;

  logic [FLOOR_W:0]    floor_neg_r, floor_neg_nxt;
  logic [THR_W-1:0]    xoff_thr_r, xoff_thr_nxt;
  logic [THR_W-1:0]    xon_thr_r, xon_thr_nxt;
  logic [FLOOR_W-1:0]  floor_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r    <= '0;
      preamble_r <= PREAMBLE_RST;
      gap_r      <= GAP_RST;
      xoff_r     <= '0;
      xon_r      <= '0;
      credit_r   <= '0;
    end else if (cfg_wen) begin
      case (prl_reg_t'(cfg_addr))
        REG_DRAIN:    drain_r    <= cfg_wdata[DRAIN_W-1:0];
        REG_PREAMBLE: preamble_r <= cfg_wdata[CHARGE_W-1:0];
        REG_GAP:      gap_r      <= cfg_wdata[CHARGE_W-1:0];
        REG_XOFF:     xoff_r     <= cfg_wdata[LEVEL_W-1:0];
        REG_XON:      xon_r      <= cfg_wdata[LEVEL_W-1:0];
        REG_CREDIT:   credit_r   <= cfg_wdata[TICKS_W-1:0];
        default:      ;
      endcase
    end
  end

  // Fold the byte rounding into the thresholds so the update stage only compares
  always_comb begin
    floor_prod    = FLOOR_W'(drain_r) * FLOOR_W'(credit_r);
    floor_neg_nxt = -{1'b0, floor_prod};
    xoff_thr_nxt  = $signed({1'b0, xoff_r, {BYTE_SHIFT{1'b0}}}) - ROUND_THR;
    xon_thr_nxt   = $signed({1'b0, xon_r, {BYTE_SHIFT{1'b0}}}) - ROUND_THR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_neg_r <= '0;
      xoff_thr_r  <= -ROUND_THR;
      xon_thr_r   <= -ROUND_THR;
    end else begin
      floor_neg_r <= floor_neg_nxt;
      xoff_thr_r  <= xoff_thr_nxt;
      xon_thr_r   <= xon_thr_nxt;
    end
  end

  always_comb begin
    cfg.drain_q8  = drain_r;
    cfg.preamble  = preamble_r;
    cfg.gap       = gap_r;
    cfg.floor_neg = floor_neg_r;
    cfg.xoff_thr  = xoff_thr_r;
    cfg.xon_thr   = xon_thr_r;
  end

endmodule

// ----- rtl/core/prl_acc.sv -----
`timescale 1ns / 1ps
// Outstanding-bit accumulator, xon/xoff flag and the result register.
// Depends on prl_pkg; fed by the input stage and prl_cfg.
module prl_acc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  prl_pkg::prl_item_t         item,
  input  prl_pkg::prl_cfg_t          cfg,
  input  logic                       out_tready,
  output logic                       acc_ready,
  output logic                       out_valid,
  output logic                       out_xoff,
  output logic [prl_pkg::OUT_W-1:0]  out_bytes
);
  import prl_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pause_r, pause_nxt;
  logic             out_valid_r;
  logic             out_xoff_r;
  logic [OUT_W-1:0] out_bytes_r, bytes_nxt;

  logic [SUM_W-1:0] add_bytes;
  logic [ACC_W-1:0] cnt_ext, add_sum, sub_sum, new_ext, rnd;
  logic [ACC_W-1:0] floor_ext, xoff_ext, xon_ext;
  logic [Q_W-1:0]   q;
  logic             drain_ok;

  always_comb begin
    cnt_ext   = {cnt_r[CNT_W-1], cnt_r};
    floor_ext = {{(ACC_W-FLOOR_W-1){cfg.floor_neg[FLOOR_W]}}, cfg.floor_neg};
    xoff_ext  = {{(ACC_W-THR_W){cfg.xoff_thr[THR_W-1]}}, cfg.xoff_thr};
    xon_ext   = {{(ACC_W-THR_W){cfg.xon_thr[THR_W-1]}}, cfg.xon_thr};

    add_bytes = SUM_W'(item.line_bytes);
    if (item.cmd == CMD_LINE) begin
      add_bytes = SUM_W'(item.line_bytes)
                + (item.sop ? SUM_W'(cfg.preamble) : '0)
                + (item.eop ? SUM_W'(cfg.gap) : '0);
    end
    add_sum  = cnt_ext + {{(ACC_W-SUM_W-BYTE_SHIFT){1'b0}}, add_bytes, {BYTE_SHIFT{1'b0}}};
    sub_sum  = cnt_ext - {{(ACC_W-DRAIN_W){1'b0}}, cfg.drain_q8};
    drain_ok = $signed(cnt_ext) > $signed(floor_ext);

    cnt_nxt   = cnt_r;
    pause_nxt = pause_r;
    case (item.cmd)
      CMD_LINE: begin
        cnt_nxt = sat_cnt(add_sum);
        if (!pause_r && $signed({cnt_nxt[CNT_W-1], cnt_nxt}) > $signed(xoff_ext)) begin
          pause_nxt = 1'b1;
        end
      end
      CMD_DRAIN: begin
        if (drain_ok) begin
          cnt_nxt = sat_cnt(sub_sum);
          if (pause_r && $signed({cnt_nxt[CNT_W-1], cnt_nxt}) <= $signed(xon_ext)) begin
            pause_nxt = 1'b0;
          end
        end
      end
      CMD_RAW: cnt_nxt = sat_cnt(add_sum);
      default: ;
    endcase

    // (bits + 7) / 8 with truncation toward zero, then clamp to the output range
    new_ext = {cnt_nxt[CNT_W-1], cnt_nxt};
    rnd     = new_ext + ROUND_Q8;
    q       = rnd[ACC_W-1:BYTE_SHIFT]
            + Q_W'(rnd[ACC_W-1] && (|rnd[BYTE_SHIFT-1:0]));
    if (q[Q_W-1:OUT_W-1] == '0 || q[Q_W-1:OUT_W-1] == '1) begin
      bytes_nxt = q[OUT_W-1:0];
    end else if (q[Q_W-1]) begin
      bytes_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      bytes_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pause_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      cnt_r       <= cnt_nxt;
      pause_r     <= pause_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_xoff_r  <= pause_nxt;
      out_bytes_r <= bytes_nxt;
    end
  end

  assign acc_ready = !out_valid_r || out_tready;
  assign out_valid = out_valid_r;
  assign out_xoff  = out_xoff_r;
  assign out_bytes = out_bytes_r;

  a_xoff_set_only_on_line: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.cmd != CMD_LINE && !pause_r) |=> !pause_r)
    else $error("xoff raised by an item other than a line send");

  a_xoff_clear_only_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.cmd != CMD_DRAIN && pause_r) |=> pause_r)
    else $error("xoff released by an item other than a drain tick");

  a_count_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cnt_r) && $stable(pause_r))
    else $error("count changed without an item");

  a_result_tracks_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_xoff_r == pause_r))
    else $error("held result disagrees with the xoff flag");

endmodule

// ----- rtl/core/port_rate_limiter_xon_xoff.sv -----
`timescale 1ns / 1ps
// Leaky-bucket port rate limiter with xon/xoff pause request.
// Path: input register, then update + result register, from input accept to result valid.
// Throughput: one item per cycle while the result is not stalled; the count and xoff flag update once per item.
// A stalled result is held while the input register still takes the next item if it is empty.
// Reset (rst_n low, synchronous): count and xoff clear, config registers return to defaults.
// Depends on prl_pkg, prl_cfg and prl_acc.
module port_rate_limiter_xon_xoff (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [prl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [prl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // line_bytes[9:0], zero pad
  input  logic [2:0]                      in_tuser,   // cmd[1:0], start_of_packet
  input  logic                            in_tlast,   // end_of_packet
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata   // xoff, outstanding_bytes[23:0], zero pad
);
  import prl_pkg::*;

  logic              s1_valid_r;
  prl_item_t         s1_item_r;
  prl_cfg_t          cfg;
  logic              acc_ready;
  logic              fire;
  logic              out_xoff;
  logic [OUT_W-1:0]  out_bytes;

  prl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign fire      = s1_valid_r && acc_ready;
  assign in_tready = !s1_valid_r || acc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.cmd        <= prl_cmd_t'(in_tuser[1:0]);
      s1_item_r.sop        <= in_tuser[2];
      s1_item_r.eop        <= in_tlast;
      s1_item_r.line_bytes <= in_tdata[BYTES_W-1:0];
    end
  end

  prl_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (s1_item_r),
    .cfg        (cfg),
    .out_tready (out_tready),
    .acc_ready  (acc_ready),
    .out_valid  (out_tvalid),
    .out_xoff   (out_xoff),
    .out_bytes  (out_bytes)
  );

  assign out_tdata = {7'b0, out_bytes, out_xoff};

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !acc_ready) |=> s1_valid_r)
    else $error("stalled item dropped from the input register");

endmodule
